[hw/rtl/three_term_recurrence_checksum_macros.svh]
// Assertion macros shared by the checksum RTL.
// Each macro expects clk and rst_n to be visible at the point of use.
`ifndef THREE_TERM_RECURRENCE_CHECKSUM_MACROS_SVH
`define THREE_TERM_RECURRENCE_CHECKSUM_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define TTC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define TTC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/tt_chk_pkg.sv]
// Types and constants for the three-term recurrence checksum.
// No dependencies; used by tt_chk_core and the top level.
package tt_chk_pkg;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned TERM_W = 16;

  // Recurrence coefficients: alpha = pos*17, beta = pos*31, both mod 256.
  localparam logic [BYTE_W-1:0] ALPHA_STEP   = 8'd17;
  localparam logic [BYTE_W-1:0] BETA_STEP    = 8'd31;
  localparam logic [BYTE_W-1:0] FIRST_OFFSET = 8'd7;
  localparam logic [TERM_W-1:0] MOD_VAL      = 16'hFFFF;

  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic              last_byte;
  } in_item_t;

  typedef struct packed {
    logic [TERM_W-1:0] checksum;
    logic              message_done;
  } out_item_t;

endpackage

[hw/rtl/tt_chk_core.sv]
// Recurrence state and combinational next-term datapath (two multiplies, mod 65535 fold).
// Depends on tt_chk_pkg and the checksum assertion macros.
`include "three_term_recurrence_checksum_macros.svh"

module tt_chk_core (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 step,
  input  tt_chk_pkg::in_item_t item,
  output logic [15:0]          term
);
  import tt_chk_pkg::*;

  logic [TERM_W-1:0] prev_r, prev_nxt;
  logic [TERM_W-1:0] cur_r, cur_nxt;
  logic [BYTE_W-1:0] pos_r, pos_nxt;
  logic              in_msg_r, in_msg_nxt;

  logic [2*BYTE_W-1:0] alpha_full, beta_full;
  logic [BYTE_W-1:0]   alpha, beta;
  logic [BYTE_W:0]     coef;
  logic [24:0]         prod;
  logic [23:0]         sub;
  logic [25:0]         diff;
  logic                neg;
  logic [24:0]         mag;
  logic [16:0]         fold1;
  logic [15:0]         fold2;
  logic [15:0]         red;
  logic [15:0]         rec_term;

  always_comb begin
    alpha_full = pos_r * ALPHA_STEP;
    beta_full  = pos_r * BETA_STEP;
    alpha      = alpha_full[BYTE_W-1:0];
    beta       = beta_full[BYTE_W-1:0];
    coef       = {1'b0, item.data_byte} + {1'b0, alpha};
    prod       = coef * cur_r;
    sub        = beta * prev_r;
    diff       = {1'b0, prod} - {2'b00, sub};
    neg        = diff[25];
    mag        = neg ? 25'(-diff) : diff[24:0];
    // 2^16 = 1 mod 65535: end-around fold twice, then map 65535 to 0
    fold1      = {1'b0, mag[15:0]} + {8'b0, mag[24:16]};
    fold2      = fold1[15:0] + {15'b0, fold1[16]};
    red        = (fold2 == MOD_VAL) ? '0 : fold2;
    // negative: 16-bit wrap gives (1 - d) mod 65535
    if (!neg) begin
      rec_term = red;
    end else if (red == 16'd0) begin
      rec_term = 16'd1;
    end else if (red == 16'd1) begin
      rec_term = 16'd0;
    end else begin
      rec_term = 16'(-red);
    end
    term = in_msg_r ? rec_term
                    : {8'b0, item.data_byte} + {8'b0, FIRST_OFFSET};
  end

  always_comb begin
    prev_nxt   = prev_r;
    cur_nxt    = cur_r;
    pos_nxt    = pos_r;
    in_msg_nxt = in_msg_r;
    if (step) begin
      if (item.last_byte) begin
        prev_nxt   = 16'd1;
        cur_nxt    = '0;
        pos_nxt    = '0;
        in_msg_nxt = 1'b0;
      end else begin
        prev_nxt   = in_msg_r ? cur_r : 16'd1;
        cur_nxt    = term;
        pos_nxt    = pos_r + 8'd1;
        in_msg_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r   <= 16'd1;
      cur_r    <= '0;
      pos_r    <= '0;
      in_msg_r <= 1'b0;
    end else begin
      prev_r   <= prev_nxt;
      cur_r    <= cur_nxt;
      pos_r    <= pos_nxt;
      in_msg_r <= in_msg_nxt;
    end
  end

  `TTC_ASSERT_NEXT(a_last_restarts, step && item.last_byte, !in_msg_r && pos_r == 8'd0, "last byte did not restart recurrence")
  `TTC_ASSERT_NEXT(a_mid_in_msg, step && !item.last_byte, in_msg_r, "message not open after a non-final byte")
  `TTC_ASSERT_NOW(a_term_range, in_msg_r, rec_term != MOD_VAL, "recurrence term out of range")

endmodule

[hw/rtl/three_term_recurrence_checksum.sv]
// Top level of the three-term recurrence checksum: input register, core, result register.
// Depends on tt_chk_pkg, tt_chk_core and the checksum assertion macros.
//
// Usage:
//   in_valid/in_stall/in_data carry one message byte per transfer, with last_byte
//   marking the final byte of a message. Every input transfer produces exactly one
//   output transfer on out_valid/out_stall/out_data: the running checksum after
//   that byte, and message_done equal to last_byte.
//   Path: an accepted byte is registered in the input register, its term is computed
//   combinationally from it and the core state, and it then loads into the result
//   register, which raises out_valid; a stall can hold it at either register.
//   Throughput: one byte per cycle while out_stall is low. The recurrence closes
//   through the core's state registers (a 16x9 and a 16x8 multiply, end-around fold).
//   Stall: while the result waits, the input register can still take one byte;
//   in_stall rises only when both registers are full and out_stall is high.
//   Reset (rst_n low, synchronous): both registers empty, previous term 1,
//   current term 0, position 0, next byte opens a new message.
`include "three_term_recurrence_checksum_macros.svh"

module three_term_recurrence_checksum (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  tt_chk_pkg::in_item_t  in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output tt_chk_pkg::out_item_t out_data
);
  import tt_chk_pkg::*;

  // input stage
  logic      s1_valid_r, s1_valid_nxt;
  in_item_t  s1_item_r;
  // result stage
  logic      out_valid_r, out_valid_nxt;
  out_item_t out_data_r;

  logic        res_adv;   // result register may load this cycle
  logic        in_xfer;   // input transfer at this edge
  logic        step;      // s1 item moves into the result register
  logic [15:0] term;

  assign res_adv  = !out_valid_r || !out_stall;
  assign in_stall = s1_valid_r && !res_adv;
  assign in_xfer  = in_valid && !in_stall;
  assign step     = s1_valid_r && res_adv;

  tt_chk_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (step),
    .item  (s1_item_r),
    .term  (term)
  );

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_xfer) begin
      s1_valid_nxt = 1'b1;
    end else if (step) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = res_adv ? s1_valid_r : out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_item_r <= in_data;
    end
    if (step) begin
      out_data_r.checksum     <= term;
      out_data_r.message_done <= s1_item_r.last_byte;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `TTC_ASSERT_NOW(a_stall_only_full, in_stall, s1_valid_r && out_valid_r, "input stalled with room free")
  `TTC_ASSERT_NEXT(a_step_fills_out, step, out_valid_r, "stepped item missing from result register")
  `TTC_ASSERT_NOW(a_out_range, out_valid_r, out_data_r.checksum != MOD_VAL, "checksum out of range")

endmodule
